[hw/rtl/teac_pkg.sv]
`default_nettype none
package teac_pkg;

  // field widths fixed by the port list
  localparam int TYPE_BITS = 16;
  localparam int PERM_BITS = 16;
  localparam int CLASS_BITS = 3;
  localparam int PROC_BITS = 32;
  localparam int TIME_BITS = 32;

  localparam int RULE_DEPTH_DEF = 64;
  localparam int LOG_DEPTH_DEF = 64;

  typedef enum logic [1:0] {
    K_CHECK = 2'd0,
    K_WRITE = 2'd1,
    K_READ  = 2'd2,
    K_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    V_ALLOW = 2'd0,
    V_DENY  = 2'd1,
    V_AUDIT = 2'd2
  } verdict_t;

  // mode register codes; the unused code behaves as enforcing
  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_PERMISSIVE = 2'd1;
  localparam logic [1:0] MODE_ENFORCE = 2'd2;

  // configuration register indexes
  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_RULES = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_TAIL,
    ST_DECIDE,
    ST_LOG2,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic                  on;
    logic [TYPE_BITS-1:0]  subj;
    logic [TYPE_BITS-1:0]  obj;
    logic [CLASS_BITS-1:0] cls;
    logic [PERM_BITS-1:0]  allow;
    logic [PERM_BITS-1:0]  audit;
  } rule_word_t;

  typedef struct packed {
    verdict_t              verdict;
    logic [TYPE_BITS-1:0]  subj;
    logic [TYPE_BITS-1:0]  obj;
    logic [CLASS_BITS-1:0] cls;
    logic [PERM_BITS-1:0]  perm;
    logic [PROC_BITS-1:0]  proc;
    logic [TIME_BITS-1:0]  stamp;
  } log_entry_t;

  typedef struct packed {
    logic     fin;
    logic     is_read;
    verdict_t verdict;
  } teac_res_t;

endpackage
`default_nettype wire

[hw/rtl/teac_rule_store.sv]
`default_nettype none
module teac_rule_store #(
  parameter int DEPTH = teac_pkg::RULE_DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [AW-1:0]       waddr,
  input  wire teac_pkg::rule_word_t wdata,
  input  wire logic                re,
  input  wire logic [AW-1:0]       raddr,
  output teac_pkg::rule_word_t     rdata
);

  teac_pkg::rule_word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/teac_log_ring.sv]
`default_nettype none
module teac_log_ring #(
  parameter int DEPTH = teac_pkg::LOG_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire teac_pkg::log_entry_t wdata,
  input  wire logic                 re,
  input  wire logic [5:0]           slot,
  output logic [CW-1:0]             count,
  output logic                      present,
  output teac_pkg::log_entry_t      rdata
);

  teac_pkg::log_entry_t mem [DEPTH];
  logic [AW-1:0] head;
  logic [CW:0] h_ext, c_ext, s_ext, oldest, idx_raw, idx;
  logic        hit;

  // oldest entry sits count places behind head, modulo the ring size
  always_comb begin
    h_ext = (CW + 1)'(head);
    c_ext = (CW + 1)'(count);
    s_ext = (CW + 1)'(slot);
    oldest = (h_ext >= c_ext) ? (h_ext - c_ext) : (h_ext + (CW + 1)'(DEPTH) - c_ext);
    idx_raw = oldest + s_ext;
    idx = (idx_raw >= (CW + 1)'(DEPTH)) ? (idx_raw - (CW + 1)'(DEPTH)) : idx_raw;
    hit = (32'(slot) < 32'(count));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[head] <= wdata;
    end
    if (re) begin
      rdata <= mem[idx[AW-1:0]];
      present <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      count <= '0;
    end else if (push) begin
      head <= (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
      if (count != CW'(DEPTH)) begin
        count <= count + CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/teac_seq.sv]
`default_nettype none
module teac_seq #(
  parameter int RULE_DEPTH = teac_pkg::RULE_DEPTH_DEF,
  localparam int AW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [1:0]                        kind,
  input  wire logic [5:0]                        slot,
  input  wire logic                              rule_on,
  input  wire logic [teac_pkg::TYPE_BITS-1:0]    subj_type,
  input  wire logic [teac_pkg::TYPE_BITS-1:0]    obj_type,
  input  wire logic [teac_pkg::CLASS_BITS-1:0]   object_class,
  input  wire logic [teac_pkg::PERM_BITS-1:0]    perm_bits,
  input  wire logic [teac_pkg::PERM_BITS-1:0]    audit_bits,
  input  wire logic                              subject_ok,
  input  wire logic                              object_ok,
  input  wire logic [teac_pkg::PROC_BITS-1:0]    proc_id,
  input  wire logic [teac_pkg::TIME_BITS-1:0]    time_ms,
  input  wire logic [1:0]                        mode,
  input  wire logic [6:0]                        rules_in_use,
  output logic                                   busy,
  output logic                                   rule_we,
  output logic [AW-1:0]                          rule_waddr,
  output teac_pkg::rule_word_t                   rule_wdata,
  output logic                                   rule_re,
  output logic [AW-1:0]                          rule_raddr,
  input  wire teac_pkg::rule_word_t              rule_rdata,
  output logic                                   log_push,
  output teac_pkg::log_entry_t                   log_wdata,
  output logic                                   log_re,
  output teac_pkg::teac_res_t                    res
);

  teac_pkg::state_t state, state_next;
  logic [AW-1:0] clr_addr, walk_addr, walk_last;
  logic          cmp_valid;
  logic [teac_pkg::PERM_BITS-1:0] granted, audited;
  teac_pkg::kind_t kind_q;
  logic [teac_pkg::TYPE_BITS-1:0] subj_q, obj_q;
  logic [teac_pkg::CLASS_BITS-1:0] cls_q;
  logic [teac_pkg::PERM_BITS-1:0] perm_q;
  logic [teac_pkg::PROC_BITS-1:0] proc_q;
  logic [teac_pkg::TIME_BITS-1:0] time_q;
  teac_pkg::verdict_t verdict_q, push_verdict;
  teac_pkg::kind_t kind_in;
  logic accept, labels_ok, deny, audit_hit, hit;

  always_comb begin
    kind_in = teac_pkg::kind_t'(kind);
    accept = start && (state == teac_pkg::ST_IDLE);
    labels_ok = subject_ok && object_ok;
    deny = ((granted & perm_q) != perm_q);
    audit_hit = ((audited & perm_q) != '0);
    hit = rule_rdata.on && (rule_rdata.subj == subj_q) && (rule_rdata.obj == obj_q) &&
          (rule_rdata.cls == cls_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= teac_pkg::ST_CLEAR;
      clr_addr <= '0;
      cmp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cmp_valid <= (state == teac_pkg::ST_WALK);
      if (state == teac_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= kind_in;
      subj_q <= subj_type;
      obj_q <= obj_type;
      cls_q <= object_class;
      perm_q <= perm_bits;
      proc_q <= proc_id;
      time_q <= time_ms;
      granted <= '0;
      audited <= '0;
      walk_addr <= '0;
      walk_last <= (32'(rules_in_use) < RULE_DEPTH) ? AW'(rules_in_use - 7'd1)
                                                    : AW'(RULE_DEPTH - 1);
      verdict_q <= (kind_in == teac_pkg::K_CHECK && mode != teac_pkg::MODE_OFF && !labels_ok)
                   ? teac_pkg::V_DENY : teac_pkg::V_ALLOW;
    end else begin
      if (state == teac_pkg::ST_WALK) begin
        walk_addr <= walk_addr + AW'(1);
      end
      if (cmp_valid && hit) begin
        granted <= granted | rule_rdata.allow;
        audited <= audited | rule_rdata.audit;
      end
      if (state == teac_pkg::ST_DECIDE && deny) begin
        verdict_q <= (mode == teac_pkg::MODE_PERMISSIVE) ? teac_pkg::V_AUDIT : teac_pkg::V_DENY;
      end
    end
  end

  always_comb begin
    state_next = state;
    busy = (state != teac_pkg::ST_IDLE);
    rule_we = 1'b0;
    rule_waddr = AW'(slot);
    rule_wdata.on = rule_on;
    rule_wdata.subj = subj_type;
    rule_wdata.obj = obj_type;
    rule_wdata.cls = object_class;
    rule_wdata.allow = perm_bits;
    rule_wdata.audit = audit_bits;
    rule_re = 1'b0;
    rule_raddr = walk_addr;
    log_push = 1'b0;
    log_re = 1'b0;
    push_verdict = teac_pkg::V_AUDIT;
    res.fin = 1'b0;
    res.is_read = (kind_q == teac_pkg::K_READ);
    res.verdict = verdict_q;
    unique case (state)
      teac_pkg::ST_CLEAR: begin
        rule_we = 1'b1;
        rule_waddr = clr_addr;
        rule_wdata = '0;
        if (clr_addr == AW'(RULE_DEPTH - 1)) begin
          state_next = teac_pkg::ST_IDLE;
        end
      end
      teac_pkg::ST_IDLE: begin
        if (start) begin
          state_next = teac_pkg::ST_FIN;
          unique case (kind_in)
            teac_pkg::K_CHECK: begin
              if (mode != teac_pkg::MODE_OFF && labels_ok) begin
                state_next = (rules_in_use == 7'd0) ? teac_pkg::ST_DECIDE : teac_pkg::ST_WALK;
              end
            end
            teac_pkg::K_WRITE: begin
              rule_we = (32'(slot) < RULE_DEPTH);
            end
            teac_pkg::K_READ: begin
              log_re = 1'b1;
            end
            teac_pkg::K_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      teac_pkg::ST_WALK: begin
        rule_re = 1'b1;
        if (walk_addr == walk_last) begin
          state_next = teac_pkg::ST_TAIL;
        end
      end
      teac_pkg::ST_TAIL: begin
        state_next = teac_pkg::ST_DECIDE;
      end
      teac_pkg::ST_DECIDE: begin
        state_next = teac_pkg::ST_FIN;
        if (deny) begin
          log_push = 1'b1;
          push_verdict = teac_pkg::V_DENY;
          if (mode == teac_pkg::MODE_PERMISSIVE) begin
            state_next = teac_pkg::ST_LOG2;
          end
        end else if (audit_hit) begin
          log_push = 1'b1;
        end
      end
      teac_pkg::ST_LOG2: begin
        log_push = 1'b1;
        state_next = teac_pkg::ST_FIN;
      end
      teac_pkg::ST_FIN: begin
        res.fin = 1'b1;
        state_next = teac_pkg::ST_IDLE;
      end
      default: begin
        state_next = teac_pkg::ST_IDLE;
      end
    endcase
    log_wdata.verdict = push_verdict;
    log_wdata.subj = subj_q;
    log_wdata.obj = obj_q;
    log_wdata.cls = cls_q;
    log_wdata.perm = perm_q;
    log_wdata.proc = proc_q;
    log_wdata.stamp = time_q;
  end

endmodule
`default_nettype wire

[hw/rtl/type_enforcement_access_check_unit.sv]
`default_nettype none
// type enforcement access check with a rule table and an audit ring
//
// a word is taken at a rising edge with start high and busy low; kind picks
// the operation: an access check, a rule table write, or a read of the audit
// log at an offset from its oldest entry. exactly one result word comes back,
// held on the result ports for the single cycle in which done is high; the
// receiver cannot stall it. a new word may be started in that same cycle.
//
// path from accept to done:
//   rule write, log read, unused kind, disabled mode, bad label: straight to finish
//   check: walk over n entries, tail, decide, a second log write when a
//     permissive denial logs twice, then finish; with n = 0 straight to decide
// n = min(rules_in_use, RULE_DEPTH); the walk reads one rule table entry per cycle
// from the single read port of the rule memory, so a check's time grows with n
// the decision may write the log ring once or twice, one entry per cycle
//
// after rst the block is busy while it sweeps the rule memory, marking every
// entry inactive; mode comes up enforcing, rules_in_use
// zero, the log empty. configuration writes are taken at any edge with cfg_we
// high, also during the sweep, and must only be made while the block is idle
module type_enforcement_access_check_unit #(
  parameter int RULE_DEPTH = teac_pkg::RULE_DEPTH_DEF,
  parameter int LOG_DEPTH = teac_pkg::LOG_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // command channel
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        kind,
  input  wire logic [5:0]                        slot,
  input  wire logic                              rule_on,
  input  wire logic [teac_pkg::TYPE_BITS-1:0]    subj_type,
  input  wire logic [teac_pkg::TYPE_BITS-1:0]    obj_type,
  input  wire logic [teac_pkg::CLASS_BITS-1:0]   object_class,
  input  wire logic [teac_pkg::PERM_BITS-1:0]    perm_bits,
  input  wire logic [teac_pkg::PERM_BITS-1:0]    audit_bits,
  input  wire logic                              subject_ok,
  input  wire logic                              object_ok,
  input  wire logic [teac_pkg::PROC_BITS-1:0]    proc_id,
  input  wire logic [teac_pkg::TIME_BITS-1:0]    time_ms,
  // configuration write port
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_index,
  input  wire logic [6:0]                        cfg_data,
  // result channel
  output logic                                   done,
  output logic [1:0]                             verdict,
  output logic                                   entry_present,
  output logic [1:0]                             entry_verdict,
  output logic [teac_pkg::TYPE_BITS-1:0]         entry_subject,
  output logic [teac_pkg::TYPE_BITS-1:0]         entry_object,
  output logic [teac_pkg::CLASS_BITS-1:0]        entry_class,
  output logic [teac_pkg::PERM_BITS-1:0]         entry_perm,
  output logic [teac_pkg::PROC_BITS-1:0]         entry_proc,
  output logic [teac_pkg::TIME_BITS-1:0]         entry_time,
  output logic [6:0]                             entries_held
);

  localparam int RAW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
  localparam int LCW = $clog2(LOG_DEPTH + 1);

  // configuration registers
  logic [1:0] mode;
  logic [6:0] rules_in_use;

  // rule memory ports
  logic                 rule_we, rule_re;
  logic [RAW-1:0]       rule_waddr, rule_raddr;
  teac_pkg::rule_word_t rule_wdata, rule_rdata;

  // log ring ports
  logic                 log_push, log_re, log_present;
  teac_pkg::log_entry_t log_wdata, log_rdata;
  logic [LCW-1:0]       log_count;

  teac_pkg::teac_res_t  res;
  logic                 show_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= teac_pkg::MODE_ENFORCE;
      rules_in_use <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        teac_pkg::CFG_MODE:  mode <= cfg_data[1:0];
        teac_pkg::CFG_RULES: rules_in_use <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  teac_seq #(
    .RULE_DEPTH(RULE_DEPTH)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .start(start),
    .kind(kind),
    .slot(slot),
    .rule_on(rule_on),
    .subj_type(subj_type),
    .obj_type(obj_type),
    .object_class(object_class),
    .perm_bits(perm_bits),
    .audit_bits(audit_bits),
    .subject_ok(subject_ok),
    .object_ok(object_ok),
    .proc_id(proc_id),
    .time_ms(time_ms),
    .mode(mode),
    .rules_in_use(rules_in_use),
    .busy(busy),
    .rule_we(rule_we),
    .rule_waddr(rule_waddr),
    .rule_wdata(rule_wdata),
    .rule_re(rule_re),
    .rule_raddr(rule_raddr),
    .rule_rdata(rule_rdata),
    .log_push(log_push),
    .log_wdata(log_wdata),
    .log_re(log_re),
    .res(res)
  );

  teac_rule_store #(
    .DEPTH(RULE_DEPTH)
  ) u_rules (
    .clk(clk),
    .we(rule_we),
    .waddr(rule_waddr),
    .wdata(rule_wdata),
    .re(rule_re),
    .raddr(rule_raddr),
    .rdata(rule_rdata)
  );

  // the slot goes straight to the ring so the read issues on the accept edge
  teac_log_ring #(
    .DEPTH(LOG_DEPTH)
  ) u_log (
    .clk(clk),
    .rst(rst),
    .push(log_push),
    .wdata(log_wdata),
    .re(log_re),
    .slot(slot),
    .count(log_count),
    .present(log_present),
    .rdata(log_rdata)
  );

  // entry fields read as zero unless a log read found an entry
  assign show_entry = res.is_read && log_present;

  // result register, loaded in the sequencer's finish cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (res.fin) begin
      verdict <= res.verdict;
      entries_held <= 7'(log_count);
      entry_present <= show_entry;
      if (show_entry) begin
        entry_verdict <= log_rdata.verdict;
        entry_subject <= log_rdata.subj;
        entry_object <= log_rdata.obj;
        entry_class <= log_rdata.cls;
        entry_perm <= log_rdata.perm;
        entry_proc <= log_rdata.proc;
        entry_time <= log_rdata.stamp;
      end else begin
        entry_verdict <= '0;
        entry_subject <= '0;
        entry_object <= '0;
        entry_class <= '0;
        entry_perm <= '0;
        entry_proc <= '0;
        entry_time <= '0;
      end
    end
  end

  // an accepted word keeps the block busy until its result is out
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a word");

  // a result only follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without work in flight");

  // a log read never carries a check verdict
  a_read_verdict: assert property (@(posedge clk) disable iff (rst)
    (done && entry_present) |-> (verdict == 2'(teac_pkg::V_ALLOW)))
    else $error("log entry returned with a nonzero verdict");

  // the ring never reports more entries than it holds
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(entries_held) <= LOG_DEPTH))
    else $error("entry count beyond ring size");

endmodule
`default_nettype wire
